@@ src/rsi_pkg.sv @@
// Shared types and constants for the RSI threshold signal block.
`timescale 1ns / 1ps
package rsi_pkg;
    localparam int SUM_W = 40;
    localparam int CHG_W = 33;
    localparam logic [1:0] REG_SYMBOL     = 2'd0;
    localparam logic [1:0] REG_LOOKBACK   = 2'd1;
    localparam logic [1:0] REG_OVERSOLD   = 2'd2;
    localparam logic [1:0] REG_OVERBOUGHT = 2'd3;
    localparam logic [13:0] RSI_FULL = 14'd10000;

    // Job handed from the front part to the back part.
    typedef struct packed {
        logic [SUM_W-1:0] gain;
        logic [SUM_W-1:0] loss;
        logic [31:0]      price;
        logic [47:0]      stamp;
    } t_job;
endpackage

@@ src/rsi_front.sv @@
// Front part: symbol filter, change ring and running sums.
`timescale 1ns / 1ps
module rsi_front #(
    parameter int MAX_LOOKBACK = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clear,
    input  logic [15:0]         i_symbol,
    input  logic [6:0]          i_lookback,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [15:0]         i_bar_symbol,
    input  logic [31:0]         i_close,
    input  logic [47:0]         i_time,
    output logic                o_job_valid,
    input  logic                i_job_ready,
    output rsi_pkg::t_job       o_job
);
    import rsi_pkg::*;
    localparam int PW = $clog2(MAX_LOOKBACK);
    localparam int LW = $clog2(MAX_LOOKBACK + 2);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001, S_READ = 3'b010, S_UPD = 3'b100
    } t_state;

    logic signed [CHG_W-1:0] r_ring [MAX_LOOKBACK];
    logic signed [CHG_W-1:0] r_old;
    t_state r_state;
    logic [31:0] r_prev, r_close;
    logic [47:0] r_time;
    logic [SUM_W-1:0] r_gain, r_loss;
    logic [PW-1:0] r_ptr;
    logic [LW-1:0] r_seen;
    logic r_job_valid;
    t_job r_job;

    logic [LW-1:0] eff;
    logic [PW-1:0] ptr_use;
    logic signed [CHG_W-1:0] diff;
    logic [SUM_W-1:0] g1, l1, g2, l2;
    logic [LW-1:0] seen_n;

    always_comb begin
        if (i_lookback == 7'd0) eff = LW'(1);
        else if ({25'd0, i_lookback} > 32'(MAX_LOOKBACK)) eff = LW'(MAX_LOOKBACK);
        else eff = LW'(i_lookback);
        ptr_use = ({{(LW > PW ? LW - PW : 1){1'b0}}, r_ptr} >= eff) ? '0 : r_ptr;
        diff = $signed({1'b0, r_close}) - $signed({1'b0, r_prev});
        g1 = r_gain; l1 = r_loss;
        if (r_seen > eff) begin
            if (r_old > 0) g1 = r_gain - SUM_W'(r_old);
            else l1 = r_loss - SUM_W'(-r_old);
        end
        g2 = g1; l2 = l1;
        if (diff > 0) g2 = g1 + SUM_W'(diff);
        else l2 = l1 + SUM_W'(-diff);
        seen_n = (r_seen < eff + LW'(1)) ? r_seen + LW'(1) : r_seen;
    end

    assign o_ready = (r_state == S_IDLE) && !r_job_valid && !i_clear;
    assign o_job_valid = r_job_valid;
    assign o_job = r_job;

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) r_old <= r_ring[ptr_use];
        if (r_state == S_UPD && r_seen != '0) r_ring[ptr_use] <= diff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_state <= S_IDLE;
            r_prev <= '0; r_gain <= '0; r_loss <= '0; r_ptr <= '0; r_seen <= '0;
            r_job_valid <= 1'b0;
        end else begin
            if (r_job_valid && i_job_ready) r_job_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid && o_ready && i_bar_symbol == i_symbol) begin
                    r_close <= i_close; r_time <= i_time; r_state <= S_READ;
                end
                S_READ: r_state <= S_UPD;
                S_UPD: begin
                    if (r_seen != '0) begin
                        r_gain <= g2; r_loss <= l2;
                        r_ptr <= ({{(LW > PW ? LW - PW : 1){1'b0}}, ptr_use} + 1 >= eff)
                                 ? '0 : PW'(ptr_use + 1'b1);
                    end
                    r_prev <= r_close;
                    r_seen <= seen_n;
                    if (seen_n >= eff + LW'(1)) begin
                        r_job_valid <= 1'b1;
                        r_job.gain <= (r_seen != '0) ? g2 : r_gain;
                        r_job.loss <= (r_seen != '0) ? l2 : r_loss;
                        r_job.price <= r_close; r_job.stamp <= r_time;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid && !i_job_ready |=> r_job_valid) else $error("job dropped");
    a_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= LW'(MAX_LOOKBACK + 1)) else $error("count overflow");
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE) else $error("ready while busy");
endmodule

@@ src/rsi_back.sv @@
// Back part: RSI ratio, threshold tests and confidence by serial division.
`timescale 1ns / 1ps
module rsi_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [13:0]   i_oversold,
    input  logic [13:0]   i_overbought,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    input  rsi_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [110:0]  o_data
);
    import rsi_pkg::*;
    localparam int W = 60;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_MUL = 5'b00010, S_CMP = 5'b00100,
        S_DIV = 5'b01000, S_OUT = 5'b10000
    } t_state;

    t_state r_state;
    t_job r_job;
    logic [W-1:0] r_num, r_den, r_on, r_bn, r_rem, r_dv, r_cn, r_cd;
    logic [5:0] r_cnt;
    logic [15:0] r_q, r_conf;
    logic [13:0] r_rsi;
    logic r_kind, r_phase, r_sat, r_valid;
    logic [110:0] r_data;
    logic [W-1:0] rem2, cand;

    assign o_job_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;
    assign o_data = r_data;
    assign rem2 = {r_rem[W-2:0], 1'b0};
    assign cand = {r_rem[W-2:0], r_dv[W-1]};

    // Two serial dividers share one loop: RSI (14 bits), for signals confidence (16 bits).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_valid <= 1'b0;
        end else begin
            if (r_valid && i_ready && r_state != S_OUT) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_job_valid) begin
                    r_job <= i_job; r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_job.loss == '0) begin
                        r_num <= W'(10000); r_den <= W'(1);
                    end else begin
                        r_num <= W'(r_job.gain) * W'(10000);
                        r_den <= W'(r_job.gain) + W'(r_job.loss);
                    end
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_on <= W'(i_oversold) * r_den;
                    r_bn <= W'(i_overbought) * r_den;
                    r_cd <= W'(RSI_FULL - i_overbought) * r_den;
                    r_rem <= '0; r_dv <= r_num; r_cnt <= 6'd0; r_q <= '0;
                    r_phase <= 1'b0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!r_phase) begin
                        // restoring division num/den over 60 bits, keep low 14
                        r_dv <= {r_dv[W-2:0], 1'b0};
                        if (r_cnt == 6'(W - 1)) begin
                            r_phase <= 1'b1; r_cnt <= 6'd0;
                            r_rsi <= {r_q[12:0], (cand >= r_den)};
                            if (r_num < r_on) begin
                                r_kind <= 1'b0; r_rem <= r_on - r_num; r_cn <= r_on;
                                r_sat <= (r_num == '0);
                            end else if (r_num > r_bn && i_overbought < RSI_FULL) begin
                                r_kind <= 1'b1; r_rem <= r_num - r_bn; r_cn <= r_cd;
                                r_sat <= (r_num - r_bn) >= r_cd;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_cnt <= r_cnt + 6'd1;
                            if (cand >= r_den) begin
                                r_rem <= cand - r_den;
                                r_q <= {r_q[14:0], 1'b1};
                            end else begin
                                r_rem <= cand;
                                r_q <= {r_q[14:0], 1'b0};
                            end
                        end
                    end else begin
                        if (rem2 >= r_cn) begin
                            r_rem <= rem2 - r_cn; r_conf <= {r_conf[14:0], 1'b1};
                        end else begin
                            r_rem <= rem2; r_conf <= {r_conf[14:0], 1'b0};
                        end
                        if (r_cnt == 6'd15) r_state <= S_OUT;
                        else r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_OUT: if (!r_valid || i_ready) begin
                    r_valid <= 1'b1;
                    r_data <= {r_job.stamp, r_job.price, r_rsi,
                               r_sat ? 16'hFFFF : r_conf, r_kind};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_data)) else $error("result lost");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_ready |-> r_state == S_IDLE) else $error("bad handoff");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_cnt < 6'(W)) else $error("divider overrun");
endmodule

@@ src/rsi_threshold_signal_unit.sv @@
// Top level of the RSI threshold signal block.
`timescale 1ns / 1ps
// Usage: price bars enter as words on s_axis (tdata: bar_symbol, close_price,
// bar_time from the lowest bit). Bars of other symbols are taken and dropped.
// Signals leave on m_axis (tdata: signal_kind, confidence, strength_index,
// reference_price, signal_time from the lowest bit).
// The front part takes a watched bar through accept, ring read and sum
// update, set by the single ring memory port, and then waits for its job
// register to empty. The back part takes a job through a multiply, a compare
// setup and a 60-step RSI division, then for a signal a 16-step confidence
// division in the same bit-serial loop; a job without a signal ends there.
// The back part takes a new job only once it is idle again, so while it
// is busy the front part holds at most one job in its register.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data; writing the lookback clears
// history. Reset restores register defaults and empties the history.
// When the receiver stalls, the result holds on m_axis and the back part
// stops once its next signal is ready; the front keeps going until its job
// register is full.
module rsi_threshold_signal_unit #(
    parameter int MAX_LOOKBACK = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // bar_symbol, close_price, bar_time
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata    // kind, confidence, rsi, price, time
);
    import rsi_pkg::*;
    logic [15:0] r_sym;
    logic [6:0]  r_lb;
    logic [13:0] r_os, r_ob;
    logic        clr, jv, jr;
    t_job        job;
    logic [110:0] data;

    assign clr = i_cfg_we && i_cfg_idx == REG_LOOKBACK;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym <= '0; r_lb <= 7'd14; r_os <= 14'd3000; r_ob <= 14'd7000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SYMBOL:     r_sym <= i_cfg_data;
                REG_LOOKBACK:   r_lb <= i_cfg_data[6:0];
                REG_OVERSOLD:   r_os <= i_cfg_data[13:0];
                REG_OVERBOUGHT: r_ob <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    rsi_front #(.MAX_LOOKBACK(MAX_LOOKBACK)) u_front (
        .i_clk, .i_rst_n, .i_clear(clr), .i_symbol(r_sym), .i_lookback(r_lb),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_bar_symbol(s_axis_tdata[15:0]), .i_close(s_axis_tdata[47:16]),
        .i_time(s_axis_tdata[95:48]), .o_job_valid(jv), .i_job_ready(jr), .o_job(job));

    rsi_back u_back (
        .i_clk, .i_rst_n, .i_oversold(r_os), .i_overbought(r_ob),
        .i_job_valid(jv), .o_job_ready(jr), .i_job(job),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(data));

    assign m_axis_tdata = {1'b0, data};
endmodule

@@ tb/rsi_threshold_signal_unit_tb.sv @@
// Self-checking testbench for the RSI threshold signal block.
`timescale 1ns / 1ps
module rsi_threshold_signal_unit_tb;
    import rsi_pkg::*;

    localparam int  LOOK_MAX = 64;
    localparam int  LIMIT = 1500000;
    localparam bit  SIG_LONG = 1'b0;
    localparam bit  SIG_SHORT = 1'b1;

    typedef struct packed {
        logic [47:0] stamp;
        logic [31:0] price;
        logic [15:0] sym;
    } t_bar;

    typedef struct packed {
        logic [47:0] stamp;
        logic [31:0] price;
        logic [13:0] rsi;
        logic [15:0] conf;
        logic        kind;
    } t_sig;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;

    rsi_threshold_signal_unit dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state.
    logic signed [33:0] chg_ring [LOOK_MAX];
    logic [31:0]  prev_close;
    logic [63:0]  gains, losses;
    int unsigned  rptr, seen;
    logic [15:0]  cfg_sym;
    logic [6:0]   cfg_look;
    logic [13:0]  cfg_os, cfg_ob;

    t_bar  bar_q[$];
    t_sig  sig_q[$];
    int    mismatches = 0;
    bit    failed = 0;
    bit    idle_en = 1;
    bit    hold_tx = 0;
    bit    rx_long_go = 0;
    bit    rx_long = 0;
    bit    tx_taken = 0;
    longint cycles = 0;

    function automatic logic [15:0] q16(logic [63:0] num, logic [63:0] den);
        logic [15:0] q;
        q = 0;
        if (num >= den) return 16'hFFFF;
        for (int i = 0; i < 16; i++) begin
            num = num << 1;
            q = q << 1;
            if (num >= den) begin
                num = num - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    task automatic wipe_history();
        prev_close = 0; gains = 0; losses = 0; rptr = 0; seen = 0;
    endtask

    task automatic add_bar(t_bar b);
        bar_q = {bar_q, b};
    endtask

    task automatic predict_bar(t_bar b);
        int unsigned l;
        logic signed [33:0] d, old;
        logic [63:0] num, den, o, ob;
        t_sig s;
        l = (cfg_look == 0) ? 1 : (cfg_look > LOOK_MAX ? LOOK_MAX : cfg_look);
        if (b.sym != cfg_sym) return;
        if (seen >= 1) begin
            d = $signed({2'b00, b.price}) - $signed({2'b00, prev_close});
            if (rptr >= l) rptr = 0;
            if (seen > l) begin
                old = chg_ring[rptr];
                if (old > 0) gains -= 64'(old);
                else losses -= 64'(-old);
            end
            chg_ring[rptr] = d;
            if (d > 0) gains += 64'(d);
            else losses += 64'(-d);
            rptr = (rptr + 1 >= l) ? 0 : rptr + 1;
        end
        prev_close = b.price;
        if (seen < l + 1) seen++;
        if (seen < l + 1) return;
        if (losses == 0) begin
            num = 10000; den = 1;
        end else begin
            num = 10000 * gains; den = gains + losses;
        end
        o = cfg_os; ob = cfg_ob;
        if (num < o * den) begin
            s.kind = SIG_LONG;
            s.conf = q16(o * den - num, o * den);
        end else if (num > ob * den && ob < 10000) begin
            s.kind = SIG_SHORT;
            s.conf = q16(num - ob * den, (10000 - ob) * den);
        end else return;
        s.rsi = 14'(num / den);
        s.price = b.price;
        s.stamp = b.stamp;
        sig_q = {sig_q, s};
    endtask

    // Accepted input words are predicted at the edge that takes them.
    always @(posedge i_clk) begin
        tx_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (tx_taken) begin
            predict_bar(t_bar'(s_axis_tdata));
            void'(bar_q.pop_front());
        end
    end

    // Sender: feeds bars from the pending queue with random gaps.
    int tx_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && !tx_taken) begin
                // Hold the word until it is taken.
            end else if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (idle_en && $urandom_range(0, 9) == 0) begin
                tx_gap <= $urandom_range(1, 17) - 1;
                s_axis_tvalid <= 1'b0;
            end else if (bar_q.size() > 0 && !hold_tx) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= bar_q[0];
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here once it is requested.
    always begin
        @(posedge rx_long_go);
        rx_long = 1'b1;
        repeat (600) @(negedge i_clk);
        rx_long = 1'b0;
    end

    // Receiver: random stalls plus an optional long hold-off.
    int rx_gap = 0;
    always @(negedge i_clk) begin
        if (rx_long) begin
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            rx_gap <= $urandom_range(1, 17) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: compares each signal word with the oldest prediction.
    always @(posedge i_clk) begin
        t_sig got, want;
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_sig'(m_axis_tdata[110:0]);
            if (sig_q.size() == 0) begin
                failed = 1;
                if (mismatches < 10) $display("unexpected signal %h", got);
                mismatches++;
            end else begin
                want = sig_q.pop_front();
                if (got !== want) begin
                    failed = 1;
                    if (mismatches < 10)
                        $display({"mismatch: exp kind %0d conf %0d rsi %0d px %0d t %0d,",
                                  " got kind %0d conf %0d rsi %0d px %0d t %0d"},
                            want.kind, want.conf, want.rsi, want.price, want.stamp,
                            got.kind, got.conf, got.rsi, got.price, got.stamp);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_SYMBOL:     cfg_sym = val;
            REG_LOOKBACK: begin
                cfg_look = val[6:0];
                wipe_history();
            end
            REG_OVERSOLD:   cfg_os = val[13:0];
            REG_OVERBOUGHT: cfg_ob = val[13:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (bar_q.size() > 0 || sig_q.size() > 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    function automatic t_bar mk(logic [15:0] s, logic [31:0] p);
        t_bar b;
        b.sym = s; b.price = p;
        b.stamp = 48'({$urandom, $urandom});
        return b;
    endfunction

    // A random walk of prices for the watched symbol, with foreign bars mixed in.
    task automatic queue_walk(int n, int step);
        logic [31:0] p;
        p = $urandom;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) add_bar(mk(cfg_sym ^ 16'h1, $urandom));
            case ($urandom_range(0, 9))
                0: p = $urandom;
                1: ;
                default: p = p + $urandom_range(0, 2 * step) - step;
            endcase
            add_bar(mk(cfg_sym, p));
        end
    endtask

    initial begin
        cfg_sym = 0; cfg_look = 14; cfg_os = 3000; cfg_ob = 7000;
        wipe_history();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: short lookback, extreme prices, flat series, foreign bars.
        write_reg(REG_SYMBOL, 16'hFFFF);
        write_reg(REG_LOOKBACK, 16'd2);
        write_reg(REG_OVERSOLD, 16'd3000);
        write_reg(REG_OVERBOUGHT, 16'd7000);
        add_bar(mk(16'h0000, 32'd5));
        add_bar(mk(16'hFFFF, 32'hFFFF_FFFF));
        add_bar(mk(16'hFFFF, 32'd0));
        add_bar(mk(16'hFFFF, 32'd0));
        add_bar(mk(16'hFFFF, 32'hFFFF_FFFF));
        add_bar(mk(16'hFFFF, 32'hFFFF_FFFF));
        add_bar(mk(16'hFFFF, 32'hFFFF_FFFF));
        add_bar(mk(16'hFFFF, 32'd100));
        add_bar(mk(16'hFFFF, 32'd90));
        add_bar(mk(16'hFFFF, 32'd80));
        add_bar(mk(16'hFFFF, 32'd81));
        add_bar(mk(16'hFFFF, 32'd81));
        add_bar(mk(16'h7FFE, 32'd1));
        drain();
        // Lookback 0 acts as 1; thresholds at the extremes.
        write_reg(REG_LOOKBACK, 16'd0);
        write_reg(REG_OVERSOLD, 16'd10000);
        write_reg(REG_OVERBOUGHT, 16'd0);
        for (int i = 0; i < 8; i++) add_bar(mk(16'hFFFF, 32'd50 + i % 3));
        drain();
        write_reg(REG_OVERSOLD, 16'h3FFF);
        write_reg(REG_OVERBOUGHT, 16'h3FFF);
        for (int i = 0; i < 4; i++) add_bar(mk(16'hFFFF, 32'd60 - i));
        drain();

        // Random phases across lookbacks and thresholds.
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(REG_SYMBOL, 16'($urandom));
            case (ph % 4)
                0: write_reg(REG_LOOKBACK, 16'd1);
                1: write_reg(REG_LOOKBACK, 16'd64);
                2: write_reg(REG_LOOKBACK, 16'h7F);
                default: write_reg(REG_LOOKBACK, 16'($urandom_range(1, 20)));
            endcase
            write_reg(REG_OVERSOLD, 16'($urandom_range(2000, 5000)));
            write_reg(REG_OVERBOUGHT, 16'($urandom_range(5000, 8000)));
            if (ph == 9) idle_en = 0;
            queue_walk(90, (ph % 3 == 0) ? 1000 : 20);
            if (ph == 3) begin
                rx_long_go = 1'b1;
                while (bar_q.size() > 0) @(negedge i_clk);
                hold_tx = 1;
                while (sig_q.size() > 0) @(negedge i_clk);
                hold_tx = 0;
            end
            drain();
        end

        repeat (200) @(negedge i_clk);
        if (!failed && sig_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
